>>> sv/aip_pkg.sv
// Shared types and constants of the streaming ASCII integer parser.
package aip_pkg;

    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 6;
    localparam int VALUE_W    = 32;
    localparam int CONSUMED_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd63;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] CH_DIG_0   = 8'd48;
    localparam logic [CHAR_W-1:0] CH_DIG_9   = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'd88;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'd120;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd10;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_DIGITS = 2'd1,
        STATUS_RANGE     = 2'd2,
        STATUS_BAD_BASE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        status_t               status;
        logic [CONSUMED_W-1:0] consumed;
    } out_item_t;

    typedef struct packed {
        logic [BASE_W-1:0] number_base;
        logic              signed_mode;
    } cfg_t;

    // Digit value of a character, NO_DIGIT when it is not alphanumeric.
    function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = NO_DIGIT;
        if (c inside {[CH_DIG_0:CH_DIG_9]})
        begin
            d = BASE_W'(c - CH_DIG_0);
        end
        else if (c inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            d = BASE_W'(c - CH_LOWER_A + LETTER_BIAS);
        end
        else if (c inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            d = BASE_W'(c - CH_UPPER_A + LETTER_BIAS);
        end
        return d;
    endfunction

endpackage

>>> sv/aip_in_stage.sv
// Input register stage with valid/stall handshake.
module aip_in_stage
    import aip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     out_free,
    output logic     advance,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // A final character needs room in the result register; others always advance.
    assign advance  = valid_reg && (!item_reg.last || out_free);
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

endmodule

>>> sv/aip_core.sv
// Parse state registers and the per-character step logic.
module aip_core
    import aip_pkg::*;
#(
    parameter int WORD_BITS     = 32,
    parameter int POSITION_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int PROD_W = WORD_BITS + BASE_W;

    typedef enum logic [5:0] {
        PH_SKIP   = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    localparam logic [WORD_BITS-1:0] HALF     = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] POS_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    phase_t                   phase_reg, phase_next, phase_dec, take_phase;
    logic [WORD_BITS-1:0]     acc_reg, acc_next;
    logic                     negative_reg, negative_next;
    logic                     overflow_reg, overflow_next;
    logic [BASE_W-1:0]        base_reg, base_next;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] end_mark_reg, end_mark_next;

    logic [CHAR_W-1:0] c;
    logic [BASE_W-1:0] digit;
    logic [BASE_W-1:0] take_base;
    logic              take;
    logic              first_char;
    logic              is_space;
    logic              base_ok;
    logic [PROD_W-1:0] prod_sum;
    logic [WORD_BITS-1:0] word_val;
    logic [63:0]          value_wide;
    logic [31:0]          consumed_wide;
    status_t              status_val;

    assign c        = item.char_code;
    assign digit    = digit_of(c);
    assign is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    assign base_ok  = cfg.number_base inside {BASE_AUTO, [BASE_MIN:BASE_MAX]};

    assign position_next = (position_reg != {POSITION_BITS{1'b1}})
                         ? position_reg + 1'b1 : position_reg;

    // Decide what this character does to the parse.
    always_comb
    begin
        phase_dec     = phase_reg;
        base_next     = base_reg;
        negative_next = negative_reg;
        first_char    = 1'b0;
        take          = 1'b0;
        take_base     = base_reg;
        take_phase    = PH_DIGITS;
        case (phase_reg)
            PH_SKIP:
            begin
                if (!is_space)
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        negative_next = (c == CH_MINUS);
                        phase_dec     = PH_SIGN;
                    end
                    else
                    begin
                        first_char = 1'b1;
                    end
                end
            end
            PH_SIGN:
            begin
                first_char = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    phase_dec = PH_PREFIX;
                end
                else if (digit < base_reg)
                begin
                    take = 1'b1;
                end
                else
                begin
                    phase_dec = PH_DONE;
                end
            end
            PH_PREFIX:
            begin
                if (digit < BASE_HEX)
                begin
                    base_next = BASE_HEX;
                    take_base = BASE_HEX;
                    take      = 1'b1;
                end
                else
                begin
                    phase_dec = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (digit < base_reg)
                begin
                    take = 1'b1;
                end
                else
                begin
                    phase_dec = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_dec = PH_DONE;
            end
            default:
            begin
                phase_dec = PH_DONE;
            end
        endcase

        // First character past whitespace and sign fixes the base.
        if (first_char)
        begin
            if (!base_ok)
            begin
                phase_dec = PH_DONE;
            end
            else if (cfg.number_base == BASE_AUTO)
            begin
                if (c == CH_DIG_0)
                begin
                    base_next  = BASE_OCT;
                    take_base  = BASE_OCT;
                    take       = 1'b1;
                    take_phase = PH_ZERO;
                end
                else
                begin
                    base_next = BASE_DEC;
                    take_base = BASE_DEC;
                    if (digit < BASE_DEC)
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        phase_dec = PH_DONE;
                    end
                end
            end
            else
            begin
                base_next = cfg.number_base;
                take_base = cfg.number_base;
                if (cfg.number_base == BASE_HEX && c == CH_DIG_0)
                begin
                    take       = 1'b1;
                    take_phase = PH_ZERO;
                end
                else if (digit < cfg.number_base)
                begin
                    take = 1'b1;
                end
                else
                begin
                    phase_dec = PH_DONE;
                end
            end
        end
    end

    // One multiply-add by the radix; any bit above the word means overflow.
    assign prod_sum = PROD_W'(acc_reg) * PROD_W'(take_base) + PROD_W'(digit);

    always_comb
    begin
        phase_next    = phase_dec;
        acc_next      = acc_reg;
        overflow_next = overflow_reg;
        end_mark_next = end_mark_reg;
        if (take)
        begin
            if (prod_sum[PROD_W-1:WORD_BITS] != '0)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                acc_next = prod_sum[WORD_BITS-1:0];
            end
            end_mark_next = position_next;
            phase_next    = take_phase;
        end
    end

    // Final result from the state after this character.
    always_comb
    begin
        word_val   = '0;
        status_val = STATUS_OK;
        if (!base_ok)
        begin
            status_val = STATUS_BAD_BASE;
        end
        else if (end_mark_next == '0)
        begin
            status_val = STATUS_NO_DIGITS;
        end
        else if (cfg.signed_mode)
        begin
            if (overflow_next)
            begin
                status_val = STATUS_RANGE;
                word_val   = negative_next ? HALF : POS_MAX;
            end
            else if (negative_next)
            begin
                if (acc_next > HALF)
                begin
                    status_val = STATUS_RANGE;
                    word_val   = HALF;
                end
                else
                begin
                    word_val = '0 - acc_next;
                end
            end
            else if (acc_next > POS_MAX)
            begin
                status_val = STATUS_RANGE;
                word_val   = POS_MAX;
            end
            else
            begin
                word_val = acc_next;
            end
        end
        else
        begin
            if (overflow_next)
            begin
                status_val = STATUS_RANGE;
                word_val   = ALL_ONES;
            end
            else
            begin
                word_val = negative_next ? ('0 - acc_next) : acc_next;
            end
        end
    end

    assign value_wide    = 64'(word_val);
    assign consumed_wide = (base_ok && end_mark_next != '0) ? 32'(end_mark_next) : '0;

    assign result.value    = value_wide[VALUE_W-1:0];
    assign result.status   = status_val;
    assign result.consumed = consumed_wide[CONSUMED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            acc_reg      <= '0;
            negative_reg <= 1'b0;
            overflow_reg <= 1'b0;
            base_reg     <= BASE_DEC;
            position_reg <= '0;
            end_mark_reg <= '0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                // Start the next string fresh.
                phase_reg    <= PH_SKIP;
                acc_reg      <= '0;
                negative_reg <= 1'b0;
                overflow_reg <= 1'b0;
                base_reg     <= BASE_DEC;
                position_reg <= '0;
                end_mark_reg <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                negative_reg <= negative_next;
                overflow_reg <= overflow_next;
                base_reg     <= base_next;
                position_reg <= position_next;
                end_mark_reg <= end_mark_next;
            end
        end
    end

endmodule

>>> sv/aip_out_stage.sv
// Result register with valid/stall handshake.
module aip_out_stage
    import aip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t result,
    output logic      out_free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Free when empty or when the held result transfers this cycle.
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

endmodule

>>> sv/ascii_integer_parser.sv
// Top level of the streaming ASCII integer parser.
//
// Input channel (in_valid / in_stall / in_data) carries one character per
// transfer; in_data.last marks the final character of a string. For every
// string exactly one result leaves on the output channel (out_valid /
// out_stall / out_data): value, status and consumed count, strtol style in
// signed mode and strtoul style in unsigned mode.
// Configuration: cfg_write with cfg_index selects number_base (index 0) or
// signed_mode (index 1); write them only while no string is in flight.
// Throughput: one character per cycle, except while a final character waits
// on a held result; a single multiply-add of the accumulator by the radix
// lies between the input and result registers. A final character sits in
// the input register, loads the result register once that is free, and
// from there can transfer out.
// Reset: both channels empty, parse state cleared, number_base 10, signed.
// Stall: a held result does not block ordinary characters; they keep
// flowing. A final character waits in the input register while the result
// register is still held, and in_stall stays high until that result leaves.
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int WORD_BITS     = 32,
    parameter int POSITION_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    in_item_t  item;
    out_item_t result;
    logic      advance;
    logic      out_free;

    // Configuration registers, written live.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NUMBER_BASE: cfg_next.number_base = cfg_data[BASE_W-1:0];
                REG_SIGNED_MODE: cfg_next.signed_mode = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.number_base <= BASE_DEC;
            cfg_reg.signed_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    aip_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    // Advance the parse state by one character per cycle whenever the input stage advances.
    aip_core #(
        .WORD_BITS     (WORD_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Capture the result when a final character steps through.
    aip_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && item.last),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> tb/tb.sv
// Testbench for the streaming ASCII integer parser: directed table, random strings, scoreboard.
`timescale 1ns / 1ps

module tb;

    import aip_pkg::*;

    localparam int                 IDLE_LIMIT = 4000;
    localparam logic [VALUE_W-1:0] SIGNED_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] SIGNED_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [CHAR_W-1:0]  NOT_ALNUM  = 8'hFF;
    localparam logic [CONSUMED_W-1:0] POS_TOP = 16'hFFFF;

    // Parse phases of the software view of the block.
    typedef enum logic [2:0] {
        P_BLANK,
        P_SIGN,
        P_ZERO,
        P_PREFIX,
        P_DIGITS,
        P_DONE
    } parse_phase_e;

    // One character waiting to go out, with an optional hand-typed result.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } char_slot_t;

    // One row of the directed table.
    typedef struct {
        logic [BASE_W-1:0]     base;
        bit                    sgn;
        string                 text;
        bit                    typed;
        logic [VALUE_W-1:0]    value;
        status_t               status;
        logic [CONSUMED_W-1:0] consumed;
    } row_t;

    logic      clk;
    logic      rst_n      = 1'b0;
    logic      in_valid   = 1'b0;
    logic      in_stall;
    in_item_t  in_data    = '0;
    logic      out_valid;
    logic      out_stall  = 1'b0;
    out_item_t out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ascii_integer_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the parser state and of its registers.
    logic [VALUE_W-1:0]    acc;
    parse_phase_e          phase_now;
    bit                    neg;
    bit                    ovf;
    logic [BASE_W-1:0]     abase;
    logic [CONSUMED_W-1:0] pos;
    logic [CONSUMED_W-1:0] end_pos;
    logic [BASE_W-1:0]     cfg_base;
    bit                    cfg_signed;

    char_slot_t  pending_chars[$];
    out_item_t   expected_results[$];
    byte unsigned text_buf[$];
    char_slot_t  held_char;
    bit          drv_got;
    out_item_t   drv_res;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int quiet_cycles       = 0;

    row_t rows [25];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [CHAR_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_DIG_0 && c <= CH_DIG_9)
            return c - CH_DIG_0;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return c - CH_LOWER_A + LETTER_BIAS;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c - CH_UPPER_A + LETTER_BIAS;
        return NOT_ALNUM;
    endfunction

    function automatic bit base_ok();
        return cfg_base == BASE_AUTO || (cfg_base >= BASE_MIN && cfg_base <= BASE_MAX);
    endfunction

    task automatic clear_parse();
        acc       = '0;
        phase_now = P_BLANK;
        neg       = 1'b0;
        ovf       = 1'b0;
        abase     = BASE_DEC;
        pos       = '0;
        end_pos   = '0;
    endtask

    // Fold one digit into the accumulator; an overflow freezes it and sets the flag.
    task automatic add_digit(input logic [CHAR_W-1:0] d);
        longint unsigned lim;
        lim = (longint'(ALL_ONES) - d) / abase;
        if (acc > lim)
            ovf = 1'b1;
        else
            acc = VALUE_W'(longint'(acc) * abase + d);
        end_pos   = pos;
        phase_now = P_DIGITS;
    endtask

    // First character past blanks and sign: fix the radix in use here.
    task automatic open_number(input logic [CHAR_W-1:0] c, input logic [CHAR_W-1:0] d);
        if (!base_ok())
        begin
            phase_now = P_DONE;
            return;
        end
        if (cfg_base == BASE_AUTO)
        begin
            if (c == CH_DIG_0)
            begin
                abase = BASE_OCT;
                add_digit('0);
                phase_now = P_ZERO;
                return;
            end
            abase = BASE_DEC;
        end
        else
        begin
            abase = cfg_base;
            if (cfg_base == BASE_HEX && c == CH_DIG_0)
            begin
                add_digit('0);
                phase_now = P_ZERO;
                return;
            end
        end
        if (d < abase)
            add_digit(d);
        else
            phase_now = P_DONE;
    endtask

    // Build the result of a finished string from the mirrored state.
    function automatic out_item_t string_result();
        out_item_t r;
        r        = '0;
        r.status = STATUS_OK;
        if (!base_ok())
            r.status = STATUS_BAD_BASE;
        else if (end_pos == 0)
            r.status = STATUS_NO_DIGITS;
        else
        begin
            r.consumed = end_pos;
            if (cfg_signed)
            begin
                if (ovf)
                begin
                    r.status = STATUS_RANGE;
                    r.value  = neg ? SIGNED_MIN : SIGNED_MAX;
                end
                else if (neg)
                begin
                    if (acc > SIGNED_MIN)
                    begin
                        r.status = STATUS_RANGE;
                        r.value  = SIGNED_MIN;
                    end
                    else
                        r.value = -acc;
                end
                else if (acc > SIGNED_MAX)
                begin
                    r.status = STATUS_RANGE;
                    r.value  = SIGNED_MAX;
                end
                else
                    r.value = acc;
            end
            else if (ovf)
            begin
                r.status = STATUS_RANGE;
                r.value  = ALL_ONES;
            end
            else
                r.value = neg ? -acc : acc;
        end
        return r;
    endfunction

    // Advance the mirror by one transferred character; report a result on the final one.
    task automatic advance_parse(input in_item_t it, output bit done, output out_item_t res);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] d;
        c    = it.char_code;
        d    = char_value(c);
        done = 1'b0;
        res  = '0;
        if (pos != POS_TOP)
            pos++;
        case (phase_now)
            P_BLANK:
            begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        neg       = (c == CH_MINUS);
                        phase_now = P_SIGN;
                    end
                    else
                        open_number(c, d);
                end
            end
            P_SIGN:
                open_number(c, d);
            P_ZERO:
            begin
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                    phase_now = P_PREFIX;
                else if (d < abase)
                    add_digit(d);
                else
                    phase_now = P_DONE;
            end
            P_PREFIX:
            begin
                // the 0x only counts when a hex digit follows it
                if (d < BASE_HEX)
                begin
                    abase = BASE_HEX;
                    add_digit(d);
                end
                else
                    phase_now = P_DONE;
            end
            P_DIGITS:
            begin
                if (d < abase)
                    add_digit(d);
                else
                    phase_now = P_DONE;
            end
            default:
            begin
            end
        endcase
        if (it.last)
        begin
            done = 1'b1;
            res  = string_result();
            clear_parse();
        end
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    // Queue the text buffer as one string; the final character carries last.
    task automatic push_text(input bit typed, input out_item_t want);
        char_slot_t slot;
        foreach (text_buf[i])
        begin
            slot.item.char_code = text_buf[i];
            slot.item.last      = (i == text_buf.size() - 1);
            slot.typed          = typed;
            slot.want           = want;
            pending_chars.push_back(slot);
        end
    endtask

    function automatic byte unsigned digit_char(input int v);
        if (v < 10)
            return CH_DIG_0 + v;
        if ($urandom_range(0, 1) != 0)
            return CH_LOWER_A + v - 10;
        return CH_UPPER_A + v - 10;
    endfunction

    // Mostly well-formed numbers in the current radix, with some noise and damage.
    task automatic make_random_text();
        int kind;
        int b;
        int r;
        int most;
        kind = $urandom_range(0, 9);
        text_buf.delete();
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
                text_buf.push_back($urandom_range(0, 255));
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            r = $urandom_range(CH_TAB, CH_CR + 1);
            text_buf.push_back(r > CH_CR ? CH_SPACE : r);
        end
        case ($urandom_range(0, 2))
            0: text_buf.push_back(CH_PLUS);
            1: text_buf.push_back(CH_MINUS);
            default:
            begin
            end
        endcase
        b = cfg_base;
        if (b == BASE_AUTO)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    text_buf.push_back(CH_DIG_0);
                    text_buf.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                    b = BASE_HEX;
                end
                1:
                begin
                    text_buf.push_back(CH_DIG_0);
                    b = BASE_OCT;
                end
                default:
                    b = BASE_DEC;
            endcase
        end
        else if (b < BASE_MIN || b > BASE_MAX)
            b = BASE_DEC;
        // digit counts straddle the 32-bit limit so overflow shows up often
        most = (b < 4) ? 33 : (b < 8) ? 17 : (b < 16) ? 12 : 9;
        repeat ($urandom_range(1, most))
            text_buf.push_back(digit_char($urandom_range(0, b - 1)));
        repeat ($urandom_range(0, 2))
            text_buf.push_back($urandom_range(0, 255));
        if (kind == 1)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = $urandom_range(0, 255);
    endtask

    // Hold until every character went out and every result came back, then let the pipe drain.
    task automatic settle();
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_NUMBER_BASE)
            cfg_base = data[BASE_W-1:0];
        else
            cfg_signed = data[0];
        @(posedge clk);
    endtask

    task automatic set_config(input logic [BASE_W-1:0] base, input bit sgn);
        write_reg(REG_NUMBER_BASE, base);
        write_reg(REG_SIGNED_MODE, CFG_DATA_W'(sgn));
    endtask

    // ---------------------------------------------------------------- input side

    // Offer the next character at a random moment; hold it until the transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_parse(held_char.item, drv_got, drv_res);
                if (drv_got)
                    expected_results.push_back(held_char.typed ? held_char.want : drv_res);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    held_char = pending_chars.pop_front();
                    in_data  <= held_char.item;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result side

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: expected no result, actual value %h status %0d consumed %0d",
                     $time, got.value, got.status, got.consumed);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (got.value !== want.value)
        begin
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
        end
        if (got.consumed !== want.consumed)
        begin
            $display("%0t: consumed expected %0d actual %0d",
                     $time, want.consumed, got.consumed);
            mismatches++;
        end
    endtask

    // Compare each result transfer and draw a fresh stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result(out_data);
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        out_item_t want;
        int        sent;
        logic [BASE_W-1:0] pick;

        // Typed results only where they follow at a glance; the rest go to the predictor.
        rows = '{
            '{BASE_DEC, 1'b1, "42",            1'b1, 32'd42,     STATUS_OK,        16'd2},
            '{BASE_DEC, 1'b1, "2147483647",    1'b1, SIGNED_MAX, STATUS_OK,        16'd10},
            '{BASE_DEC, 1'b1, "-2147483648",   1'b1, SIGNED_MIN, STATUS_OK,        16'd11},
            '{BASE_DEC, 1'b1, "2147483648",    1'b1, SIGNED_MAX, STATUS_RANGE,     16'd10},
            '{BASE_DEC, 1'b1, "-99999999999",  1'b1, SIGNED_MIN, STATUS_RANGE,     16'd12},
            '{BASE_DEC, 1'b1, "abc",           1'b1, 32'd0,      STATUS_NO_DIGITS, 16'd0},
            '{BASE_DEC, 1'b1, "+-5",           1'b1, 32'd0,      STATUS_NO_DIGITS, 16'd0},
            '{BASE_DEC, 1'b1, "\t\n\v\f\r -17xyz", 1'b0, 32'd0,  STATUS_OK,        16'd0},
            '{BASE_DEC, 1'b1, "12 34",         1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_DEC, 1'b1, "9",             1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{6'd1,     1'b1, "123",           1'b1, 32'd0,      STATUS_BAD_BASE,  16'd0},
            '{6'd63,    1'b1, "5",             1'b1, 32'd0,      STATUS_BAD_BASE,  16'd0},
            '{BASE_AUTO, 1'b1, "0x1F",         1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_AUTO, 1'b1, "0xg",          1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_AUTO, 1'b1, "0755",         1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_AUTO, 1'b1, "089",          1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_AUTO, 1'b1, "-0X",          1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_AUTO, 1'b1, "  +0XaB9",     1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_HEX, 1'b1, "0xffFFffFF",    1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_HEX, 1'b0, "0xFFFFFFFF",    1'b1, ALL_ONES,   STATUS_OK,        16'd10},
            '{BASE_HEX, 1'b0, "100000000",     1'b1, ALL_ONES,   STATUS_RANGE,     16'd9},
            '{BASE_DEC, 1'b0, "-1",            1'b1, ALL_ONES,   STATUS_OK,        16'd2},
            '{BASE_MIN, 1'b0, "1012",          1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_MAX, 1'b0, "zZ",            1'b0, 32'd0,      STATUS_OK,        16'd0},
            '{BASE_MAX, 1'b1, "  -",           1'b1, 32'd0,      STATUS_NO_DIGITS, 16'd0}
        };

        // Mirror the reset state, then release reset.
        clear_parse();
        cfg_base   = BASE_DEC;
        cfg_signed = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling; reconfigure only on a drained block.
        foreach (rows[i])
        begin
            if (rows[i].base != cfg_base || rows[i].sgn != cfg_signed)
            begin
                settle();
                set_config(rows[i].base, rows[i].sgn);
            end
            want.value    = rows[i].value;
            want.status   = rows[i].status;
            want.consumed = rows[i].consumed;
            text_buf.delete();
            for (int k = 0; k < rows[i].text.len(); k++)
                text_buf.push_back(rows[i].text[k]);
            push_text(rows[i].typed, want);
        end

        // Random phases: each idling mode twice, with a fresh setting per phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 71;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 71;
                end
                default:
                begin
                    sender_idle_pct    = 33;
                    receiver_stall_pct = 33;
                end
            endcase
            case (ph)
                0: pick = BASE_DEC;
                1: pick = BASE_AUTO;
                2: pick = BASE_MIN;
                3: pick = BASE_MAX;
                4: pick = BASE_HEX;
                5: pick = BASE_OCT;
                6: pick = BASE_AUTO;
                default: pick = $urandom_range(0, 63);
            endcase
            set_config(pick, $urandom_range(0, 1));

            sent = 0;
            while (sent < 80)
            begin
                make_random_text();
                sent += text_buf.size();
                push_text(1'b0, '0);
            end
        end

        // Drain, then give the pipe time to show any stray result.
        settle();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: results expected %0d more, actual 0",
                     $time, expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/aip_pkg.sv
sv/aip_in_stage.sv
sv/aip_core.sv
sv/aip_out_stage.sv
sv/ascii_integer_parser.sv
tb/tb.sv
